>>> rtl/sobel_edge_threshold_defines.svh
// ----------------------------------------------------------------------------
// sobel_edge_threshold assertion macros
// Shorthand for the concurrent checks on the edge classifier, clocked on
// aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_THRESHOLD_DEFINES_SVH
`define SOBEL_EDGE_THRESHOLD_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define SOBEL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger
`define SOBEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sobel_et_pkg.sv
// ----------------------------------------------------------------------------
// sobel_et_pkg
// Shared widths and the 3x3 tap bundle for the Sobel edge classifier.
// ----------------------------------------------------------------------------
package sobel_et_pkg;

    localparam int PIX_W     = 8;          // grey pixel
    localparam int THR_W     = 11;         // threshold and L1 magnitude
    localparam int SUM_W     = PIX_W + 2;  // a + 2b + c of three pixels
    localparam int GRAD_W    = SUM_W + 1;  // signed gradient
    localparam int OUT_ROW_W = 7;
    localparam int OUT_COL_W = 8;

    // Eight taps of the neighborhood (the centre does not enter Sobel)
    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] ml;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] tc;
        logic [PIX_W-1:0] bc;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] mr;
        logic [PIX_W-1:0] br;
    } window_t;

endpackage

>>> rtl/sobel_et_ram.sv
// ----------------------------------------------------------------------------
// sobel_et_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sobel_et_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 188
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write, and read old contents on a same-address collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sobel_et_grad.sv
// ----------------------------------------------------------------------------
// sobel_et_grad
// Horizontal and vertical 3x3 Sobel responses of one neighborhood.
// ----------------------------------------------------------------------------
module sobel_et_grad (
    input  sobel_et_pkg::window_t                   win,
    output logic signed [sobel_et_pkg::GRAD_W-1:0]  gx,
    output logic signed [sobel_et_pkg::GRAD_W-1:0]  gy
);

    logic [sobel_et_pkg::SUM_W-1:0] right_sum;
    logic [sobel_et_pkg::SUM_W-1:0] left_sum;
    logic [sobel_et_pkg::SUM_W-1:0] bottom_sum;
    logic [sobel_et_pkg::SUM_W-1:0] top_sum;

    // Weighted column and row sums, centre tap doubled
    always_comb begin
        right_sum  = {2'b00, win.tr} + {1'b0, win.mr, 1'b0} + {2'b00, win.br};
        left_sum   = {2'b00, win.tl} + {1'b0, win.ml, 1'b0} + {2'b00, win.bl};
        bottom_sum = {2'b00, win.bl} + {1'b0, win.bc, 1'b0} + {2'b00, win.br};
        top_sum    = {2'b00, win.tl} + {1'b0, win.tc, 1'b0} + {2'b00, win.tr};
    end

    assign gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    assign gy = $signed({1'b0, bottom_sum}) - $signed({1'b0, top_sum});

endmodule

>>> rtl/sobel_edge_threshold.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 Sobel edge classifier with an L1 magnitude threshold.
// ----------------------------------------------------------------------------
// Takes one raster pixel per clock, sustained, for any pattern of stalls on
// the result side that leaves room in the output register. An accepted pixel
// beat passes through stage 1, where the line-store RAM word returns and the
// gradient sums register, and stage 2, where magnitude and compare load the
// output register. The result classifies the centre one row up and one
// column left of the incoming pixel; only centres in rows 4..IMAGE_HEIGHT-4
// and columns 2..IMAGE_WIDTH-3 give a beat. The two line stores share one
// RAM word per column; they need no clearing pass after reset, since a
// centre row of 4 or more only ever sees rows written since the last frame
// start.
`include "sobel_edge_threshold_defines.svh"

module sobel_edge_threshold #(
    parameter int IMAGE_WIDTH  = 188,
    parameter int IMAGE_HEIGHT = 120
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [sobel_et_pkg::THR_W-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [sobel_et_pkg::PIX_W-1:0]       s_pixel,
    input  logic                                 s_frame_start,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sobel_et_pkg::OUT_ROW_W-1:0]   m_out_row,
    output logic [sobel_et_pkg::OUT_COL_W-1:0]   m_out_col,
    output logic                                 m_edge_res
);

    localparam int COL_W  = $clog2(IMAGE_WIDTH);
    localparam int ROW_W  = $clog2(IMAGE_HEIGHT);
    localparam int PIX_W  = sobel_et_pkg::PIX_W;
    localparam int GRAD_W = sobel_et_pkg::GRAD_W;
    localparam int THR_W  = sobel_et_pkg::THR_W;
    localparam int ORW    = sobel_et_pkg::OUT_ROW_W;
    localparam int OCW    = sobel_et_pkg::OUT_COL_W;

    // Threshold register
    logic [THR_W-1:0] thr_reg;

    // Raster counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // Stage 1: RAM data returning
    logic              s1_valid_reg;
    logic              s1_hit_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;

    // Forwarding for a read that meets the write of the same column
    logic                fwd_valid_reg;
    logic [2*PIX_W-1:0]  fwd_data_reg;

    // Window of the two previous columns
    logic [PIX_W-1:0] win_reg [6];

    // Stage 2: gradients
    logic                     s2_valid_reg;
    logic                     s2_hit_reg;
    logic signed [GRAD_W-1:0] s2_gx_reg;
    logic signed [GRAD_W-1:0] s2_gy_reg;
    logic [ROW_W-1:0]         s2_row_reg;
    logic [COL_W-1:0]         s2_col_reg;

    // Output register
    logic             m_valid_reg;
    logic [ORW-1:0]   m_row_reg;
    logic [OCW-1:0]   m_col_reg;
    logic             m_edge_reg;

    logic                     acc;
    logic [COL_W-1:0]         acc_col;
    logic [ROW_W-1:0]         acc_row;
    logic                     acc_hit;
    logic                     out_free;
    logic                     s2_adv;
    logic                     s2_free;
    logic                     s1_adv;
    logic [2*PIX_W-1:0]       ram_rd_data;
    logic [2*PIX_W-1:0]       line_data;
    logic [PIX_W-1:0]         top_px;
    logic [PIX_W-1:0]         mid_px;
    sobel_et_pkg::window_t    taps;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [GRAD_W-1:0]        abs_gx;
    logic [GRAD_W-1:0]        abs_gy;
    logic [THR_W-1:0]         mag;
    logic                     edge_next;
    logic [ROW_W+ORW-1:0]     row_ext;
    logic [COL_W+OCW-1:0]     col_ext;

    // Handshake chain: a stage moves when the one after it has room
    assign out_free = !m_valid_reg || m_ready;
    assign s2_adv   = s2_valid_reg && (!s2_hit_reg || out_free);
    assign s2_free  = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign acc      = s_valid && s_ready;

    // Position of the incoming pixel; frame start restarts the raster
    assign acc_col = s_frame_start ? '0 : col_reg;
    assign acc_row = s_frame_start ? '0 : row_reg;
    assign acc_hit = (acc_row >= ROW_W'(5)) && (acc_row <= ROW_W'(IMAGE_HEIGHT - 3)) &&
                     (acc_col >= COL_W'(3)) && (acc_col <= COL_W'(IMAGE_WIDTH - 2));

    // Threshold write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // Advance the raster counters on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (acc) begin
            if (acc_col == COL_W'(IMAGE_WIDTH - 1)) begin
                col_reg <= '0;
                row_reg <= (acc_row == ROW_W'(IMAGE_HEIGHT - 1)) ? '0 : acc_row + 1'b1;
            end else begin
                col_reg <= acc_col + 1'b1;
                row_reg <= acc_row;
            end
        end
    end

    // Line stores: {two rows above, one row above} per column
    sobel_et_ram #(
        .DATA_W (2 * PIX_W),
        .DEPTH  (IMAGE_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_px, s1_px_reg}),
        .rd_en   (acc),
        .rd_addr (acc_col),
        .rd_data (ram_rd_data)
    );

    assign line_data = fwd_valid_reg ? fwd_data_reg : ram_rd_data;
    assign top_px    = line_data[2*PIX_W-1:PIX_W];
    assign mid_px    = line_data[PIX_W-1:0];

    // Stage 1 control and forwarding flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (acc) begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= s1_adv && (s1_col_reg == acc_col);
            end else if (s1_adv) begin
                s1_valid_reg  <= 1'b0;
                fwd_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 1 payload, forwarded word and window shift
    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_hit_reg   <= acc_hit;
            s1_px_reg    <= s_pixel;
            s1_col_reg   <= acc_col;
            s1_row_reg   <= acc_row - 1'b1;
            fwd_data_reg <= {mid_px, s1_px_reg};
        end
        if (s1_adv) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_px;
            win_reg[4] <= mid_px;
            win_reg[5] <= s1_px_reg;
        end
    end

    // Gather taps: left column, centre column, incoming column
    always_comb begin
        taps.tl = win_reg[0];
        taps.ml = win_reg[1];
        taps.bl = win_reg[2];
        taps.tc = win_reg[3];
        taps.bc = win_reg[5];
        taps.tr = top_px;
        taps.mr = mid_px;
        taps.br = s1_px_reg;
    end

    sobel_et_grad u_grad (
        .win (taps),
        .gx  (gx),
        .gy  (gy)
    );

    // Stage 2 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_adv) begin
            s2_valid_reg <= 1'b0;
        end
    end

    // Stage 2 payload
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_hit_reg <= s1_hit_reg;
            s2_gx_reg  <= gx;
            s2_gy_reg  <= gy;
            s2_row_reg <= s1_row_reg;
            s2_col_reg <= s1_col_reg - 1'b1;
        end
    end

    // L1 magnitude and compare
    always_comb begin
        abs_gx    = s2_gx_reg[GRAD_W-1] ? GRAD_W'(-s2_gx_reg) : GRAD_W'(s2_gx_reg);
        abs_gy    = s2_gy_reg[GRAD_W-1] ? GRAD_W'(-s2_gy_reg) : GRAD_W'(s2_gy_reg);
        mag       = THR_W'(abs_gx) + THR_W'(abs_gy);
        edge_next = mag > thr_reg;
        row_ext   = {{ORW{1'b0}}, s2_row_reg};
        col_ext   = {{OCW{1'b0}}, s2_col_reg};
    end

    // Output register: load on a classified centre, drop on a taken beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_adv && s2_hit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv && s2_hit_reg) begin
            m_row_reg  <= row_ext[ORW-1:0];
            m_col_reg  <= col_ext[OCW-1:0];
            m_edge_reg <= edge_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_row  = m_row_reg;
    assign m_out_col  = m_col_reg;
    assign m_edge_res = m_edge_reg;

    // Checks
    `SOBEL_ASSERT_NOW(a_hit_row_range, s1_valid_reg && s1_hit_reg, (s1_row_reg >= ROW_W'(4)) && (s1_row_reg <= ROW_W'(IMAGE_HEIGHT - 4)), "classified centre row out of range")
    `SOBEL_ASSERT_NOW(a_out_from_hit, $rose(m_valid_reg), $past(s2_valid_reg && s2_hit_reg), "result beat without a classified centre")
    `SOBEL_ASSERT_NEXT(a_col_wrap, acc && (acc_col == COL_W'(IMAGE_WIDTH - 1)), col_reg == '0, "column did not wrap at end of row")
    `SOBEL_ASSERT_NOW(a_fwd_owner, fwd_valid_reg, s1_valid_reg, "forwarded line word with no beat in stage 1")

endmodule

>>> test/sobel_edge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_checker
// Watches the pixel and result channels of the Sobel edge classifier, keeps
// its own copy of the line stores, window and raster counters, and queues the
// classification due for every accepted pixel beat with an in-range centre.
// Each result beat is compared field by field against the oldest queued verdict.
// ----------------------------------------------------------------------------
module sobel_edge_checker #(
    parameter int IMAGE_WIDTH  = 188,
    parameter int IMAGE_HEIGHT = 120
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [sobel_et_pkg::THR_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [sobel_et_pkg::PIX_W-1:0]     s_pixel,
    input  logic                               s_frame_start,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [sobel_et_pkg::OUT_ROW_W-1:0] m_out_row,
    input  logic [sobel_et_pkg::OUT_COL_W-1:0] m_out_col,
    input  logic                               m_edge_res,
    output int                                 fail_count,
    output int                                 verdicts_waiting
);
    import sobel_et_pkg::*;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 edge_bit;
    } edge_verdict_t;

    pixel_t               line_above  [IMAGE_WIDTH];
    pixel_t               line_two_up [IMAGE_WIDTH];
    pixel_t               taps        [6];
    logic [OUT_ROW_W-1:0] row_q;
    logic [OUT_COL_W-1:0] col_q;
    logic [THR_W-1:0]     threshold_q;
    edge_verdict_t        verdicts_due [$];
    int                   fails = 0;

    // Advance the neighborhood by one raster pixel and queue its verdict
    task automatic classify_pixel(input pixel_t px, input logic fs);
        int            c, r, gx, gy, mag;
        int            tl, ml, bl, tc, bc, tr, mr, br;
        pixel_t        top, mid;
        edge_verdict_t v;
        if (fs) begin
            row_q = '0;
            col_q = '0;
        end
        c = col_q;
        r = row_q;

        // Read the two rows above, then shift the column down one row
        top = line_two_up[c];
        mid = line_above[c];
        line_two_up[c] = mid;
        line_above[c]  = px;

        tl = taps[0]; ml = taps[1]; bl = taps[2];
        tc = taps[3]; bc = taps[5];
        tr = top;     mr = mid;     br = px;

        // Classify the centre one row up and one column left
        if (r >= 5 && r <= IMAGE_HEIGHT - 3 && c >= 3 && c <= IMAGE_WIDTH - 2) begin
            gx  = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
            gy  = (bl + 2 * bc + br) - (tl + 2 * tc + tr);
            mag = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
            v.row      = OUT_ROW_W'(r - 1);
            v.col      = OUT_COL_W'(c - 1);
            v.edge_bit = (mag > int'(threshold_q));
            verdicts_due.push_back(v);
        end

        taps[0] = taps[3];
        taps[1] = taps[4];
        taps[2] = taps[5];
        taps[3] = top;
        taps[4] = mid;
        taps[5] = px;

        // Wrap the column at end of row and the row past the last one
        if (c + 1 >= IMAGE_WIDTH) begin
            col_q = '0;
            row_q = (r + 1 >= IMAGE_HEIGHT) ? '0 : OUT_ROW_W'(r + 1);
        end else begin
            col_q = OUT_COL_W'(c + 1);
        end
    endtask

    always @(posedge aclk) begin
        edge_verdict_t due;
        if (!aresetn) begin
            foreach (line_above[i]) line_above[i] = '0;
            foreach (line_two_up[i]) line_two_up[i] = '0;
            foreach (taps[i]) taps[i] = '0;
            row_q       = '0;
            col_q       = '0;
            threshold_q = '0;
            verdicts_due.delete();
        end else begin
            if (cfg_we)
                threshold_q = cfg_wdata;
            if (s_valid && s_ready)
                classify_pixel(s_pixel, s_frame_start);

            // Compare each result beat with the oldest pending verdict
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("unexpected result beat: out_row %0d out_col %0d edge_res %0d",
                           m_out_row, m_out_col, m_edge_res);
                    fails++;
                end else begin
                    due = verdicts_due.pop_front();
                    if (m_out_row !== due.row) begin
                        $error("out_row: expected %0d, got %0d", due.row, m_out_row);
                        fails++;
                    end
                    if (m_out_col !== due.col) begin
                        $error("out_col: expected %0d, got %0d", due.col, m_out_col);
                        fails++;
                    end
                    if (m_edge_res !== due.edge_bit) begin
                        $error("edge_res: expected %0d, got %0d", due.edge_bit, m_edge_res);
                        fails++;
                    end
                end
            end
        end
        fail_count       <= fails;
        verdicts_waiting <= verdicts_due.size();
    end

endmodule

>>> test/tb_sobel_edge_threshold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_threshold
// Streams raster frames of textured pixels into the Sobel edge classifier
// under several threshold settings and handshake pressure profiles, while
// the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_sobel_edge_threshold;
    import sobel_et_pkg::*;

    localparam int IMAGE_WIDTH   = 188;
    localparam int IMAGE_HEIGHT  = 120;
    localparam int WARMUP_PIXELS = 5 * IMAGE_WIDTH + 2;
    localparam int SEG_PIXELS    = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int THR_MAX       = (1 << THR_W) - 1;
    localparam int MAX_MAGNITUDE = 1530;
    localparam int PHASES        = 4;
    localparam int SEGS_PER_PHASE = 3;
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef enum int {
        TEX_NOISE,
        TEX_BINARY,
        TEX_FLAT,
        TEX_DIAGONAL,
        TEX_VERTICAL
    } texture_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [THR_W-1:0]     cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    pixel_t               s_pixel       = '0;
    logic                 s_frame_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [OUT_ROW_W-1:0] m_out_row;
    logic [OUT_COL_W-1:0] m_out_col;
    logic                 m_edge_res;

    int fail_count;
    int verdicts_waiting;

    // Handshake pressure, in percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    // Raster position and texture of the pixel generator
    int       gen_row = 0;
    int       gen_col = 0;
    texture_t texture = TEX_NOISE;
    int       step_pos = 0;
    int       flat_level = 128;
    logic     invert = 1'b0;

    int thr_plan [SEGS_PER_PHASE * PHASES];

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    sobel_edge_threshold #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_edge_res    (m_edge_res)
    );

    sobel_edge_checker #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) verdict_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel          (s_pixel),
        .s_frame_start    (s_frame_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_row        (m_out_row),
        .m_out_col        (m_out_col),
        .m_edge_res       (m_edge_res),
        .fail_count       (fail_count),
        .verdicts_waiting (verdicts_waiting)
    );

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one pixel beat after a random gap and hold it until accepted
    task automatic send_pixel(input pixel_t px, input logic fs);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel       <= px;
        s_frame_start <= fs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Pick the value of the pixel at the generator's raster position
    function automatic pixel_t texture_pixel();
        int   lvl;
        logic hit;
        case (texture)
            TEX_NOISE: begin
                return pixel_t'($urandom_range(255));
            end
            TEX_BINARY: begin
                return $urandom_range(1) ? 8'hFF : 8'h00;
            end
            TEX_FLAT: begin
                lvl = flat_level + int'($urandom_range(6)) - 3;
                if (lvl < 0) lvl = 0;
                if (lvl > 255) lvl = 255;
                return pixel_t'(lvl);
            end
            TEX_DIAGONAL: begin
                hit = (gen_row + gen_col) > step_pos;
                return (hit ^ invert) ? 8'hFF : 8'h00;
            end
            default: begin
                hit = gen_col > step_pos;
                return (hit ^ invert) ? 8'hFF : 8'h00;
            end
        endcase
    endfunction

    // Send the next generated pixel and track its raster position
    task automatic stream_pixel(input logic fs);
        if (fs) begin
            gen_row = 0;
            gen_col = 0;
        end
        if (gen_col == 0 && $urandom_range(9) < 3) begin
            texture    = texture_t'($urandom_range(TEX_VERTICAL));
            step_pos   = $urandom_range(IMAGE_WIDTH + IMAGE_HEIGHT);
            flat_level = $urandom_range(255);
            invert     = 1'($urandom_range(1));
        end
        send_pixel(texture_pixel(), fs);
        if (gen_col + 1 >= IMAGE_WIDTH) begin
            gen_col = 0;
            gen_row = (gen_row + 1 >= IMAGE_HEIGHT) ? 0 : gen_row + 1;
        end else begin
            gen_col++;
        end
    endtask

    // Wait until every pending verdict has come out and the pipe is empty
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_waiting != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input int value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= THR_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int plan_idx;

        thr_plan = '{0, THR_MAX, MAX_MAGNITUDE,
                     MAX_MAGNITUDE - 1, $urandom_range(200, 1200), 1,
                     $urandom_range(THR_MAX), $urandom_range(40, 400), THR_MAX,
                     255, $urandom_range(100, 700), $urandom_range(40, 400)};

        // Hold reset, then release it
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_threshold($urandom_range(300, 900));

        // Directed: field extremes, mid-frame and back-to-back frame starts
        send_pixel(8'd0,   1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0,   1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd1,   1'b0);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0,   1'b1);
        send_pixel(8'd85,  1'b0);
        send_pixel(8'd170, 1'b0);
        repeat (9) send_pixel(pixel_t'($urandom_range(255)), 1'b0);

        // Fill the rows above the first classified centre at full rate
        stream_pixel(1'b1);
        repeat (WARMUP_PIXELS) stream_pixel(1'b0);

        // Continue the raster under pressure, a new threshold for each segment
        plan_idx = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            for (int seg = 0; seg < SEGS_PER_PHASE; seg++) begin
                write_threshold(thr_plan[plan_idx]);
                plan_idx++;
                case (phase)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 81; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 81; end
                    default: begin idle_pct = 24; stall_pct = 24; end
                endcase
                repeat (SEG_PIXELS) stream_pixel(1'b0);
            end
        end

        drain_results();
        if (fail_count == 0 && verdicts_waiting == 0)
            $display("sobel_edge_threshold verification clean");
        else
            $display("sobel_edge_threshold verification failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("sobel_edge_threshold verification failed");
        $finish;
    end

endmodule
